// ===== hw/rtl/wsc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Word segmentation checker package
// Shared constants, payload structs, codes and state types of the checker.
// ---------------------------------------------------------------------------
package wsc_pkg;

  // Longest storable word in characters, and number of dictionary slots.
  localparam int unsigned MAX_WORD   = 16;
  localparam int unsigned DICT_WORDS = 64;

  // Derived widths.
  localparam int unsigned LEN_W  = $clog2(MAX_WORD + 1);
  localparam int unsigned CNT_W  = $clog2(DICT_WORDS + 1);
  localparam int unsigned ADDR_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_WORD  = 2'd0,
    OP_TEXT  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  // Kinds of result item.
  typedef enum logic [1:0] {
    KIND_STORED   = 2'd0,
    KIND_REJECTED = 2'd1,
    KIND_VERDICT  = 2'd2
  } kind_e;

  // Control sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  // Characters held newest first: index 0 is the latest character.
  typedef logic [MAX_WORD-1:0][7:0] chars_t;

  // One dictionary row: the word's length and its characters, last one first.
  typedef struct packed {
    logic [LEN_W-1:0] len;
    chars_t           chars;
  } row_t;

  // Text state seen by the matcher.
  typedef struct packed {
    chars_t           window;
    logic [LEN_W-1:0] length;
    logic [MAX_WORD:0] reach;
  } text_ctx_t;

  // Input item payload.
  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] symbol;
    logic       last;
  } in_item_t;

  // Result item payload.
  typedef struct packed {
    logic [1:0] result_kind;
    logic       breakable;
  } out_item_t;

endpackage

// ===== hw/rtl/wsc_dict_store.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Dictionary store and entry matcher
// Holds one row per stored word in a synchronous memory with registered read
// data, and tests whether the row read last ends at the newest text character.
// ---------------------------------------------------------------------------
module wsc_dict_store (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [wsc_pkg::ADDR_W-1:0] wr_addr_i,
  input  wsc_pkg::row_t            wr_row_i,
  input  logic                     rd_en_i,
  input  logic [wsc_pkg::ADDR_W-1:0] rd_addr_i,
  input  wsc_pkg::text_ctx_t       text_i,
  output logic                     entry_hit_o
);
  import wsc_pkg::*;

  row_t              mem_q [DICT_WORDS];
  row_t              rd_row_q;
  logic [MAX_WORD-1:0] char_ok;

  // Dictionary memory: one write port and one read port, read data registered.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_row_i;
    end
    if (rd_en_i) begin
      rd_row_q <= mem_q[rd_addr_i];
    end
  end

  // Each stored character must equal the text character at the same distance
  // from the end; positions beyond the word's length do not count.
  always_comb begin
    for (int j = 0; j < MAX_WORD; j++) begin
      char_ok[j] = (LEN_W'(j) >= rd_row_q.len) ||
                   (rd_row_q.chars[j] == text_i.window[j]);
    end
  end

  // The word must fit in the text seen so far and start at a reachable boundary.
  assign entry_hit_o = (rd_row_q.len != '0) && (rd_row_q.len <= text_i.length) &&
                       (&char_ok) && text_i.reach[rd_row_q.len];

endmodule

// ===== hw/rtl/word_segmentation_checker_core.sv =====
`timescale 1ns / 1ps
// Word and clear items are taken one at a time; a final word character also passes through ST_EMIT,
// from which its result is loaded into the output register.
// Text character: a scan over the stored words reads one dictionary row per cycle from the single
// read port, then ST_DRAIN follows; a final text character also passes through ST_EMIT, from which
// its verdict is loaded into the output register. A result waiting on a full output register stalls
// the input. Reset clears the word count, word builder and text state, not the dictionary.
// ---------------------------------------------------------------------------
// Word segmentation checker core
// Loads a dictionary of words and decides whether a text splits wholly into
// dictionary words, scanning every stored word for each text character.
// ---------------------------------------------------------------------------
module word_segmentation_checker_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  wsc_pkg::in_item_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output wsc_pkg::out_item_t out_data_o
);
  import wsc_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [LEN_W-1:0]  build_pos_q, build_pos_d;
  logic              build_ovf_q, build_ovf_d;
  chars_t            build_buf_q, build_buf_d;
  chars_t            window_q, window_d;
  logic [MAX_WORD:0] reach_q, reach_d;
  logic [LEN_W-1:0]  text_len_q, text_len_d;
  logic              text_last_q, text_last_d;
  logic [ADDR_W-1:0] idx_q, idx_d;
  logic              rd_vld_q, rd_vld_d;
  logic              hit_q, hit_d;
  out_item_t         res_q, res_d;
  logic              out_valid_q, out_valid_d;
  out_item_t         out_data_q, out_data_d;

  logic              accept;
  logic              out_free;
  logic              load_out;
  logic              shift_ovf;
  logic [LEN_W-1:0]  shift_pos;
  chars_t            shift_buf;
  logic              mem_we;
  row_t              wr_row;
  logic              rd_en;
  text_ctx_t         text_ctx;
  logic              entry_hit;
  logic              reach_now;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // Word builder: the character shifts in while the word still fits.
  always_comb begin
    shift_pos = build_pos_q;
    shift_buf = build_buf_q;
    shift_ovf = build_ovf_q;
    if (build_pos_q < LEN_W'(MAX_WORD)) begin
      shift_buf = {build_buf_q[MAX_WORD-2:0], in_data_i.symbol};
      shift_pos = build_pos_q + LEN_W'(1);
    end else begin
      shift_ovf = 1'b1;
    end
  end

  assign wr_row = '{len: shift_pos, chars: shift_buf};

  // Dictionary memory and matcher.
  assign text_ctx = '{window: window_q, length: text_len_q, reach: reach_q};
  assign rd_en    = (state_q == ST_SCAN);

  wsc_dict_store u_dict (
    .clk_i      (clk_i),
    .wr_en_i    (mem_we),
    .wr_addr_i  (count_q[ADDR_W-1:0]),
    .wr_row_i   (wr_row),
    .rd_en_i    (rd_en),
    .rd_addr_i  (idx_q),
    .text_i     (text_ctx),
    .entry_hit_o(entry_hit)
  );

  assign reach_now = hit_q || (rd_vld_q && entry_hit);

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_data_i.operation)
            OP_WORD:  state_d = in_data_i.last ? ST_EMIT : ST_IDLE;
            OP_TEXT:  state_d = (count_q == '0) ? ST_DRAIN : ST_SCAN;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if ((CNT_W'(idx_q) + CNT_W'(1)) == count_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: state_d = text_last_q ? ST_EMIT : ST_IDLE;
      ST_EMIT:  state_d = out_free ? ST_IDLE : ST_EMIT;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    load_out   = (state_q == ST_EMIT) && out_free;
  end

  // Datapath next values.
  always_comb begin
    count_d     = count_q;
    build_pos_d = build_pos_q;
    build_ovf_d = build_ovf_q;
    build_buf_d = build_buf_q;
    window_d    = window_q;
    reach_d     = reach_q;
    text_len_d  = text_len_q;
    text_last_d = text_last_q;
    idx_d       = idx_q;
    hit_d       = hit_q;
    res_d       = res_q;
    mem_we      = 1'b0;
    rd_vld_d    = (state_q == ST_SCAN);

    // Collect hits from the rows as they return from the memory.
    if (rd_vld_q && entry_hit) begin
      hit_d = 1'b1;
    end

    if (state_q == ST_SCAN) begin
      idx_d = idx_q + ADDR_W'(1);
    end

    // Taking a new item.
    if (accept) begin
      case (in_data_i.operation)
        OP_WORD: begin
          build_pos_d = shift_pos;
          build_buf_d = shift_buf;
          build_ovf_d = shift_ovf;
          if (in_data_i.last) begin
            res_d.breakable = 1'b0;
            if (shift_ovf || (count_q >= CNT_W'(DICT_WORDS))) begin
              res_d.result_kind = KIND_REJECTED;
            end else begin
              res_d.result_kind = KIND_STORED;
              mem_we            = 1'b1;
              count_d           = count_q + CNT_W'(1);
            end
            build_pos_d = '0;
            build_ovf_d = 1'b0;
          end
        end
        OP_TEXT: begin
          window_d    = {window_q[MAX_WORD-2:0], in_data_i.symbol};
          reach_d     = {reach_q[MAX_WORD-1:0], reach_q[0]};
          if (text_len_q < LEN_W'(MAX_WORD)) begin
            text_len_d = text_len_q + LEN_W'(1);
          end
          text_last_d = in_data_i.last;
          idx_d       = '0;
          hit_d       = 1'b0;
        end
        OP_CLEAR: begin
          count_d     = '0;
          build_pos_d = '0;
          build_ovf_d = 1'b0;
        end
        default: begin
        end
      endcase
    end

    // End of a scan: record the new boundary or give the verdict.
    if (state_q == ST_DRAIN) begin
      if (text_last_q) begin
        res_d.result_kind = KIND_VERDICT;
        res_d.breakable   = reach_now;
        window_d          = '0;
        reach_d           = {{MAX_WORD{1'b0}}, 1'b1};
        text_len_d        = '0;
      end else begin
        reach_d[0] = reach_now;
      end
    end
  end

  // Output register: holds a result until its transfer.
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (load_out) begin
      out_valid_d = 1'b1;
      out_data_d  = res_q;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      build_pos_q <= '0;
      build_ovf_q <= 1'b0;
      window_q    <= '0;
      reach_q     <= {{MAX_WORD{1'b0}}, 1'b1};
      text_len_q  <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      build_pos_q <= build_pos_d;
      build_ovf_q <= build_ovf_d;
      window_q    <= window_d;
      reach_q     <= reach_d;
      text_len_q  <= text_len_d;
      rd_vld_q    <= rd_vld_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    build_buf_q <= build_buf_d;
    text_last_q <= text_last_d;
    idx_q       <= idx_d;
    res_q       <= res_d;
    out_data_q  <= out_data_d;
  end

  // The word count never passes the number of dictionary slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DICT_WORDS))
    else $error("word count beyond dictionary size");

  // A scan only runs over a non-empty dictionary.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (count_q != '0))
    else $error("scan with empty dictionary");

  // With no text seen, only the start-of-text boundary is reachable.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (text_len_q == '0) |-> (reach_q[0] && (state_q != ST_SCAN)))
    else $error("text start boundary lost");

  // A pending result enters the output register once the register frees up.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_EMIT) && out_free) |=> out_valid_o)
    else $error("pending result not presented");

endmodule

// ===== tb/tb_word_segmentation_checker_core.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Word segmentation checker core testbench
// Drives dictionary loads, clears and texts into the checker through the
// valid/ready input channel and compares every result transfer, field by
// field, against a cycle-free predictor of the dictionary and reach state.
// A short table of directed vectors comes first, then random phases with
// different amounts of idling on either side.
// ---------------------------------------------------------------------------
module tb_word_segmentation_checker_core;
  import wsc_pkg::*;

  // Operation code that the block ignores.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam int unsigned ITEMS_PER_PHASE = 200;
  localparam int unsigned RX_HOLD_CYCLES  = 800;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned DRAIN_CYCLES    = 4 * DICT_WORDS + 16;

  typedef enum int unsigned {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_e;

  // One row of the directed table: an item repeated reps times, with last
  // only on the final repeat, and an optional typed-in result.
  typedef struct {
    in_item_t    item;
    int unsigned reps;
    bit          typed;
    bit          has_res;
    out_item_t   res;
  } vector_t;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_data_o;

  // Predictor state: dictionary, word builder and text progress.
  logic [7:0]        dict_chars [DICT_WORDS][MAX_WORD];
  int unsigned       dict_len   [DICT_WORDS];
  int unsigned       dict_count     = 0;
  int unsigned       build_len      = 0;
  bit                build_too_long = 1'b0;
  logic [7:0]        text_chars [MAX_WORD];
  logic [MAX_WORD:0] reach_bits;
  int unsigned       text_seen;

  out_item_t   pending_results [$];
  vector_t     directed_rows [$];
  int unsigned mismatch_count = 0;
  int unsigned items_sent     = 0;

  // Typed-in result of the item currently offered, if any.
  bit        row_typed = 1'b0;
  bit        row_has   = 1'b0;
  out_item_t row_res   = '0;

  idle_mode_e  idle_mode    = IDLE_NONE;
  int unsigned rx_hold_req  = 0;
  int unsigned rx_hold_left = 0;
  logic [7:0]  alpha_base   = 8'h61;
  int unsigned alpha_size   = 3;

  word_segmentation_checker_core i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Percentage of cycles in which one side idles under the given mode.
  function automatic int unsigned idle_pct(input idle_mode_e mode, input bit sender);
    case (mode)
      IDLE_SENDER:   return sender ? 57 : 0;
      IDLE_RECEIVER: return sender ? 0 : 57;
      IDLE_BOTH:     return 15;
      default:       return 0;
    endcase
  endfunction

  function automatic void restart_text();
    text_chars = '{default: 8'h00};
    reach_bits = '0;
    reach_bits[0] = 1'b1;
    text_seen = 0;
  endfunction

  // Works out the result, if any, of one accepted item and updates the
  // predictor state.
  function automatic void predict_outcome(input in_item_t item, output bit has_res,
                                          output out_item_t res);
    bit          found;
    bit          same;
    int unsigned len;
    has_res = 1'b0;
    res = '0;
    case (item.operation)
      OP_WORD: begin
        // Characters beyond the longest word are dropped and flag the word.
        if (build_len < MAX_WORD) begin
          if (dict_count < DICT_WORDS) dict_chars[dict_count][build_len] = item.symbol;
          build_len++;
        end else begin
          build_too_long = 1'b1;
        end
        if (item.last) begin
          has_res = 1'b1;
          if (build_too_long || dict_count >= DICT_WORDS) begin
            res.result_kind = KIND_REJECTED;
          end else begin
            dict_len[dict_count] = build_len;
            dict_count++;
            res.result_kind = KIND_STORED;
          end
          build_len = 0;
          build_too_long = 1'b0;
        end
      end
      OP_TEXT: begin
        for (int k = MAX_WORD - 1; k > 0; k--) text_chars[k] = text_chars[k-1];
        text_chars[0] = item.symbol;
        reach_bits = {reach_bits[MAX_WORD-1:0], 1'b0};
        if (text_seen < MAX_WORD) text_seen++;
        // A stored word ending here, starting after a reachable boundary.
        found = 1'b0;
        for (int unsigned w = 0; w < dict_count && !found; w++) begin
          len = dict_len[w];
          if (len != 0 && len <= text_seen && reach_bits[len]) begin
            same = 1'b1;
            for (int unsigned p = 0; p < len; p++) begin
              if (dict_chars[w][p] != text_chars[len-1-p]) same = 1'b0;
            end
            found = same;
          end
        end
        reach_bits[0] = found;
        if (item.last) begin
          has_res = 1'b1;
          res.result_kind = KIND_VERDICT;
          res.breakable = found;
          restart_text();
        end
      end
      OP_CLEAR: begin
        dict_count = 0;
        build_len = 0;
        build_too_long = 1'b0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic add_vector(input logic [1:0] op, input logic [7:0] sym, input bit last,
                            input int unsigned reps, input bit typed, input bit has_res,
                            input kind_e kind, input bit brk);
    vector_t row;
    row.item.operation = op;
    row.item.symbol = sym;
    row.item.last = last;
    row.reps = reps;
    row.typed = typed;
    row.has_res = has_res;
    row.res.result_kind = kind;
    row.res.breakable = brk;
    directed_rows = {directed_rows, row};
  endtask

  // Offers one item from a falling edge and returns at the falling edge after
  // its transfer, with valid still high.
  task automatic send_item(input in_item_t item, input bit typed = 1'b0,
                           input bit typed_has = 1'b0, input out_item_t typed_res = '0);
    while ($urandom_range(99) < idle_pct(idle_mode, 1'b1)) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    row_typed = typed;
    row_has = typed_has;
    row_res = typed_res;
    in_data_i <= item;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    if (item.operation != OP_UNUSED) items_sent++;
    @(negedge clk_i);
  endtask

  // Mostly characters of the current small alphabet, now and then any byte.
  function automatic logic [7:0] pick_symbol();
    if ($urandom_range(9) == 0) return 8'($urandom_range(255));
    return alpha_base + 8'($urandom_range(alpha_size - 1));
  endfunction

  // Mostly short words, some up to the longest, a few too long.
  function automatic int unsigned word_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 95) return $urandom_range(5, MAX_WORD);
    return $urandom_range(MAX_WORD + 1, MAX_WORD + 3);
  endfunction

  task automatic send_word(input int unsigned len);
    in_item_t item;
    for (int unsigned i = 0; i < len; i++) begin
      item.operation = OP_WORD;
      item.symbol = pick_symbol();
      item.last = (i == len - 1);
      send_item(item);
    end
  endtask

  // Holds the input idle until every expected result has been transferred.
  task automatic wait_results();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(negedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= idle_pct(idle_mode, 1'b0));
    end
  end

  // Checks result transfers and records the expectation of each input transfer.
  always @(posedge clk_i) begin
    out_item_t want;
    out_item_t guess;
    bit        has;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing expected",
                                    out_data_o.result_kind));
        end else begin
          want = pending_results.pop_front();
          if (out_data_o.result_kind !== want.result_kind)
            report_mismatch($sformatf("result_kind %0d, expected %0d",
                                      out_data_o.result_kind, want.result_kind));
          if (out_data_o.breakable !== want.breakable)
            report_mismatch($sformatf("breakable %0d, expected %0d",
                                      out_data_o.breakable, want.breakable));
        end
      end
      if (in_valid_i && in_ready_o) begin
        predict_outcome(in_data_i, has, guess);
        if (row_typed) begin
          has = row_has;
          guess = row_res;
        end
        if (has) pending_results = {pending_results, guess};
      end
    end
  end

  // Ends the run when no transfer has happened for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet = 0;
      else quiet++;
    end
    $display("word_segmentation_checker_core verification failed");
    $finish;
  end

  initial begin
    in_item_t    item;
    logic [7:0]  txt [$];
    int unsigned choice;
    int unsigned nwords;
    int unsigned w;
    int unsigned phase_end;
    bit          no_last;

    restart_text();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed table.
    add_vector(OP_TEXT, "x", 1'b1, 1, 1'b1, 1'b1, KIND_VERDICT, 1'b0);   // empty dictionary
    add_vector(OP_UNUSED, 8'hA5, 1'b1, 1, 1'b1, 1'b0, KIND_STORED, 1'b0);
    add_vector(OP_WORD, "a", 1'b1, 1, 1'b1, 1'b1, KIND_STORED, 1'b0);
    add_vector(OP_WORD, 8'hFF, 1'b1, 1, 1'b1, 1'b1, KIND_STORED, 1'b0);
    add_vector(OP_WORD, 8'h00, 1'b1, 1, 1'b1, 1'b1, KIND_STORED, 1'b0);
    add_vector(OP_TEXT, "a", 1'b1, 1, 1'b1, 1'b1, KIND_VERDICT, 1'b1);
    add_vector(OP_TEXT, 8'hFF, 1'b0, 1, 1'b1, 1'b0, KIND_STORED, 1'b0);
    add_vector(OP_WORD, "b", 1'b1, 1, 1'b1, 1'b1, KIND_STORED, 1'b0);    // stored mid text
    add_vector(OP_TEXT, "b", 1'b1, 1, 1'b0, 1'b0, KIND_STORED, 1'b0);
    add_vector(OP_WORD, "c", 1'b1, MAX_WORD + 1, 1'b1, 1'b1, KIND_REJECTED, 1'b0);
    add_vector(OP_TEXT, "e", 1'b1, 1, 1'b1, 1'b1, KIND_VERDICT, 1'b0);
    add_vector(OP_WORD, "e", 1'b0, 1, 1'b1, 1'b0, KIND_STORED, 1'b0);
    add_vector(OP_CLEAR, 8'h00, 1'b0, 1, 1'b1, 1'b0, KIND_STORED, 1'b0); // drops the partial word
    add_vector(OP_TEXT, "a", 1'b0, 1, 1'b1, 1'b0, KIND_STORED, 1'b0);
    add_vector(OP_WORD, "f", 1'b1, 1, 1'b1, 1'b1, KIND_STORED, 1'b0);
    add_vector(OP_CLEAR, 8'hFF, 1'b1, 1, 1'b1, 1'b0, KIND_STORED, 1'b0); // text is kept
    add_vector(OP_WORD, "a", 1'b1, 1, 1'b1, 1'b1, KIND_STORED, 1'b0);
    add_vector(OP_TEXT, "a", 1'b1, 1, 1'b0, 1'b0, KIND_STORED, 1'b0);
    add_vector(OP_TEXT, 8'h00, 1'b1, 1, 1'b1, 1'b1, KIND_VERDICT, 1'b0);
    add_vector(OP_TEXT, 8'hFF, 1'b1, 1, 1'b0, 1'b0, KIND_STORED, 1'b0);

    foreach (directed_rows[r]) begin
      for (int unsigned i = 0; i < directed_rows[r].reps; i++) begin
        item = directed_rows[r].item;
        if (i != directed_rows[r].reps - 1) item.last = 1'b0;
        send_item(item, directed_rows[r].typed,
                  directed_rows[r].has_res && (i == directed_rows[r].reps - 1),
                  directed_rows[r].res);
      end
    end
    wait_results();

    // Random phases, one per idling mode.
    for (int unsigned ph = 0; ph < 4; ph++) begin
      idle_mode = idle_mode_e'(ph);
      alpha_base = 8'($urandom_range(255));
      alpha_size = $urandom_range(2, 3);
      // Long receiver hold-off so that the block fills and stalls its input.
      if (ph == 0) rx_hold_req = RX_HOLD_CYCLES;
      // Fill the table past its capacity.
      if (ph == 2) begin
        item = '{operation: OP_CLEAR, symbol: 8'h00, last: 1'b0};
        send_item(item);
        repeat (DICT_WORDS + 2) send_word($urandom_range(1, 2));
      end
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        choice = $urandom_range(99);
        if (choice < 30) begin
          send_word(word_length());
        end else if (choice < 80 || choice >= 92) begin
          // Text: mostly a run of stored words, sometimes damaged or random.
          txt.delete();
          if (choice < 80 && dict_count != 0) begin
            nwords = $urandom_range(1, 4);
            repeat (nwords) begin
              w = $urandom_range(dict_count - 1);
              for (int unsigned p = 0; p < dict_len[w]; p++) txt = {txt, dict_chars[w][p]};
            end
            if ($urandom_range(3) == 0) txt[$urandom_range(txt.size() - 1)] = pick_symbol();
            if ($urandom_range(7) == 0) txt = {txt, pick_symbol()};
          end else begin
            nwords = ($urandom_range(9) == 0) ? $urandom_range(MAX_WORD + 1, MAX_WORD + 6)
                                              : $urandom_range(1, 6);
            repeat (nwords) txt = {txt, (choice >= 92 ? 8'($urandom_range(255))
                                                      : pick_symbol())};
          end
          no_last = ($urandom_range(19) == 0);
          foreach (txt[i]) begin
            // Now and then a word is loaded in the middle of the text.
            if (i != 0 && $urandom_range(99) < 8) send_word($urandom_range(1, 3));
            item.operation = OP_TEXT;
            item.symbol = txt[i];
            item.last = (i == txt.size() - 1) && !no_last;
            send_item(item);
          end
        end else if (choice < 85) begin
          item.operation = OP_UNUSED;
          item.symbol = 8'($urandom_range(255));
          item.last = 1'($urandom_range(1));
          send_item(item);
        end else if (choice < 88) begin
          item = '{operation: OP_CLEAR, symbol: 8'($urandom_range(255)),
                   last: 1'($urandom_range(1))};
          send_item(item);
        end else begin
          // Word cut short by a clear.
          repeat ($urandom_range(1, 3)) begin
            item = '{operation: OP_WORD, symbol: pick_symbol(), last: 1'b0};
            send_item(item);
          end
          item = '{operation: OP_CLEAR, symbol: 8'h00, last: 1'b0};
          send_item(item);
        end
      end
      wait_results();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("word_segmentation_checker_core verification clean");
    end else begin
      $display("word_segmentation_checker_core verification failed");
    end
    $finish;
  end

endmodule
